// ===== hdl/pts_pkg.sv =====
// pts_pkg: shared types, widths and reset constants for the pan/tilt servo rate stepper
// no dependencies; used by every other file of the block
package pts_pkg;

  localparam int AxisW   = 11;
  localparam int FrameW  = 32;
  localparam int AngleW  = 8;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 10;
  localparam int FsW     = 10;
  localparam int StepW   = 7;
  localparam int DelayW  = 8;
  localparam int ProdW   = 18;
  localparam int QuoW    = 17;
  localparam int CntW    = 6;

  localparam logic [CntW-1:0] ModSteps = CntW'(FrameW);
  localparam logic [CntW-1:0] DivSteps = CntW'(ProdW);

  localparam logic [AngleW-1:0] AngleRst = AngleW'(90);
  localparam logic [DelayW-1:0] DelayRst = DelayW'(2);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFullScale = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxStep   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBump      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegBaseDelay = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegPanLow    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegPanHigh   = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegTiltLow   = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegTiltHigh  = CfgIdxW'(7);

  typedef struct packed {
    logic [FsW-1:0]    full_scale;
    logic [StepW-1:0]  max_step;
    logic [StepW-1:0]  bump;
    logic [DelayW-1:0] base_delay;
    logic [AngleW-1:0] pan_low;
    logic [AngleW-1:0] pan_high;
    logic [AngleW-1:0] tilt_low;
    logic [AngleW-1:0] tilt_high;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [CntW-1:0]   count;
    logic [FrameW-1:0] dividend;
    logic [FsW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FsW-1:0]    rem;
    logic [FrameW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [QuoW-1:0]   qmag;
    logic              neg;
    logic [AngleW-1:0] angle;
    logic [AngleW-1:0] lo;
    logic [AngleW-1:0] hi;
    logic [StepW-1:0]  bump;
    logic [DelayW-1:0] base_delay;
  } axis_in_t;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [DelayW-1:0] delay;
  } axis_out_t;

endpackage

// ===== hdl/pts_if.sv =====
// pts_if: valid/ready channel interfaces for input items, result items and register writes
// depends on pts_pkg for field widths
interface pts_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [pts_pkg::AxisW-1:0] stick_pan_raw;
  logic signed [pts_pkg::AxisW-1:0] stick_tilt_raw;
  logic [pts_pkg::FrameW-1:0]    frame_index;
  modport source (output valid, stick_pan_raw, stick_tilt_raw, frame_index, input ready);
  modport sink   (input valid, stick_pan_raw, stick_tilt_raw, frame_index, output ready);
endinterface

interface pts_out_if;
  logic                       valid;
  logic                       ready;
  logic [pts_pkg::AngleW-1:0] pan_angle_out;
  logic [pts_pkg::AngleW-1:0] tilt_angle_out;
  modport source (output valid, pan_angle_out, tilt_angle_out, input ready);
  modport sink   (input valid, pan_angle_out, tilt_angle_out, output ready);
endinterface

interface pts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pts_pkg::CfgIdxW-1:0] index;
  logic [pts_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pan_tilt_servo_rate_stepper_top.sv =====
// pan_tilt_servo_rate_stepper_top: sequencer, axis state and result register
// depends on pts_pkg, pts_if, pts_cfg, pts_div and pts_axis
//
//   channel  dir  fields                                        handshake
//   in_i     in   stick_pan_raw, stick_tilt_raw, frame_index    valid/ready
//   out_o    out  pan_angle_out, tilt_angle_out                 valid/ready
//   cfg_i    in   index, data                                   valid/ready
//
// an item runs a frame modulo for each axis and a step division for each axis served,
// all on the shared divider, one after another
// in_i.ready is high only while the sequencer is idle; cfg_i is always ready
// the result register lets a new item start while the last result waits
// reset is asynchronous and restores the angles to 90 and the delays to 2
module pan_tilt_servo_rate_stepper_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_in_if.sink    in_i,
  pts_out_if.source out_o,
  pts_cfg_if.sink   cfg_i
);
  import pts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PMOD = 3'd1;
  localparam logic [2:0] S_PDIV = 3'd2;
  localparam logic [2:0] S_TMOD = 3'd3;
  localparam logic [2:0] S_TDIV = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  cfg_t      cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  axis_in_t  ax_in;
  axis_out_t ax_out;

  logic [2:0]              state_q, state_d;
  logic signed [AxisW-1:0] pan_raw_q, tilt_raw_q;
  logic [FrameW-1:0]       frame_q;
  logic [AngleW-1:0]       pan_angle_q, pan_angle_d, tilt_angle_q, tilt_angle_d;
  logic [DelayW-1:0]       pan_delay_q, pan_delay_d, tilt_delay_q, tilt_delay_d;
  logic                    out_valid_q, out_valid_d;
  logic [AngleW-1:0]       out_pan_q, out_pan_d, out_tilt_q, out_tilt_d;
  logic                    in_acc, tilt_sel;
  logic signed [AxisW-1:0] raw_sel;
  logic [AxisW-1:0]        mag;
  logic [ProdW-1:0]        prod;
  logic [FsW-1:0]          fs_nz;

  pts_cfg u_cfg (.clk_i, .rst_ni, .cfg_i, .cfg_o(cfg));
  pts_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  pts_axis u_axis (.ax_i(ax_in), .ax_o(ax_out));

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  // axis is the negated raw value; magnitude and sign kept apart
  assign tilt_sel = (state_q == S_TMOD) || (state_q == S_TDIV);
  assign raw_sel  = tilt_sel ? tilt_raw_q : pan_raw_q;
  assign mag      = raw_sel[AxisW-1] ? (~raw_sel + AxisW'(1)) : raw_sel;
  assign prod     = ProdW'(cfg.max_step) * ProdW'(mag);
  assign fs_nz    = (cfg.full_scale == '0) ? FsW'(1) : cfg.full_scale;

  always_comb begin
    ax_in.qmag       = div_rsp.quo[QuoW-1:0];
    ax_in.neg        = !raw_sel[AxisW-1] && (raw_sel != '0);
    ax_in.angle      = tilt_sel ? tilt_angle_q : pan_angle_q;
    ax_in.lo         = tilt_sel ? cfg.tilt_low : cfg.pan_low;
    ax_in.hi         = tilt_sel ? cfg.tilt_high : cfg.pan_high;
    ax_in.bump       = cfg.bump;
    ax_in.base_delay = cfg.base_delay;
  end

  always_comb begin
    state_d      = state_q;
    pan_angle_d  = pan_angle_q;
    tilt_angle_d = tilt_angle_q;
    pan_delay_d  = pan_delay_q;
    tilt_delay_d = tilt_delay_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_pan_d    = out_pan_q;
    out_tilt_d   = out_tilt_q;
    div_req      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          div_req.start    = 1'b1;
          div_req.count    = ModSteps;
          div_req.dividend = in_i.frame_index;
          div_req.divisor  = FsW'(pan_delay_q);
          state_d          = S_PMOD;
        end
      end
      S_PMOD: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          if (div_rsp.rem == '0) begin
            div_req.count    = DivSteps;
            div_req.dividend = {prod, {(FrameW-ProdW){1'b0}}};
            div_req.divisor  = fs_nz;
            state_d          = S_PDIV;
          end else begin
            div_req.count    = ModSteps;
            div_req.dividend = frame_q;
            div_req.divisor  = FsW'(tilt_delay_q);
            state_d          = S_TMOD;
          end
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          pan_angle_d      = ax_out.angle;
          pan_delay_d      = ax_out.delay;
          div_req.start    = 1'b1;
          div_req.count    = ModSteps;
          div_req.dividend = frame_q;
          div_req.divisor  = FsW'(tilt_delay_q);
          state_d          = S_TMOD;
        end
      end
      S_TMOD: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            div_req.start    = 1'b1;
            div_req.count    = DivSteps;
            div_req.dividend = {prod, {(FrameW-ProdW){1'b0}}};
            div_req.divisor  = fs_nz;
            state_d          = S_TDIV;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          tilt_angle_d = ax_out.angle;
          tilt_delay_d = ax_out.delay;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pan_d   = pan_angle_q;
          out_tilt_d  = tilt_angle_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pan_angle_q  <= AngleRst;
      tilt_angle_q <= AngleRst;
      pan_delay_q  <= DelayRst;
      tilt_delay_q <= DelayRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pan_angle_q  <= pan_angle_d;
      tilt_angle_q <= tilt_angle_d;
      pan_delay_q  <= pan_delay_d;
      tilt_delay_q <= tilt_delay_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pan_raw_q  <= in_i.stick_pan_raw;
      tilt_raw_q <= in_i.stick_tilt_raw;
      frame_q    <= in_i.frame_index;
    end
    out_pan_q  <= out_pan_d;
    out_tilt_q <= out_tilt_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pan_angle_out  = out_pan_q;
  assign out_o.tilt_angle_out = out_tilt_q;

  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pan_delay_q != '0) && (tilt_delay_q != '0)) else $error("stored delay is zero");
  a_pan_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PDIV && div_rsp.done) |=> pan_angle_q >= $past(cfg.pan_low))
    else $error("pan angle below its low limit");
  a_tilt_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TDIV && div_rsp.done) |=> tilt_angle_q >= $past(cfg.tilt_low))
    else $error("tilt angle below its low limit");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("result without an item");

endmodule

// ===== hdl/pts_cfg.sv =====
// pts_cfg: configuration register file, written through the register write channel
// depends on pts_pkg and pts_if
module pts_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  pts_cfg_if.sink       cfg_i,
  output pts_pkg::cfg_t cfg_o
);
  import pts_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid & cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_i.index)
        RegFullScale: cfg_d.full_scale = cfg_i.data[FsW-1:0];
        RegMaxStep:   cfg_d.max_step   = cfg_i.data[StepW-1:0];
        RegBump:      cfg_d.bump       = cfg_i.data[StepW-1:0];
        RegBaseDelay: cfg_d.base_delay = cfg_i.data[DelayW-1:0];
        RegPanLow:    cfg_d.pan_low    = cfg_i.data[AngleW-1:0];
        RegPanHigh:   cfg_d.pan_high   = cfg_i.data[AngleW-1:0];
        RegTiltLow:   cfg_d.tilt_low   = cfg_i.data[AngleW-1:0];
        RegTiltHigh:  cfg_d.tilt_high  = cfg_i.data[AngleW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale <= FsW'(512);
      cfg_q.max_step   <= StepW'(8);
      cfg_q.bump       <= StepW'(4);
      cfg_q.base_delay <= DelayW'(2);
      cfg_q.pan_low    <= AngleW'(0);
      cfg_q.pan_high   <= AngleW'(170);
      cfg_q.tilt_low   <= AngleW'(90);
      cfg_q.tilt_high  <= AngleW'(150);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/pts_div.sv =====
// pts_div: shared restoring divider, one quotient bit per cycle, dividend left-aligned
// depends on pts_pkg
module pts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::div_req_t req_i,
  output pts_pkg::div_rsp_t rsp_o
);
  import pts_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FsW-1:0]    rem_q, rem_d;
  logic [FrameW-1:0] dvd_q, dvd_d;
  logic [FsW-1:0]    dsr_q, dsr_d;
  logic [FsW:0]      sh;
  logic [FsW:0]      diff;
  logic              ge;

  assign sh   = {rem_q, dvd_q[FrameW-1]};
  assign ge   = sh >= {1'b0, dsr_q};
  assign diff = sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.count;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[FsW-1:0] : sh[FsW-1:0];
      dvd_d = {dvd_q[FrameW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quo  = dvd_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dsr_q) else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running division");

endmodule

// ===== hdl/pts_axis.sv =====
// pts_axis: one served axis update, step shaping, delay stretch and angle clamp
// depends on pts_pkg
module pts_axis (
  input  pts_pkg::axis_in_t  ax_i,
  output pts_pkg::axis_out_t ax_o
);
  import pts_pkg::*;

  logic                    zero, slow;
  logic [StepW-1:0]        slow_diff;
  logic [DelayW+StepW-1:0] stretch;
  logic [DelayW-1:0]       dly_raw;
  logic [QuoW:0]           dmag;
  logic signed [QuoW+2:0]  sum, lo_s, hi_s, c1, c2;

  assign zero      = ax_i.qmag == '0;
  assign slow      = !zero && (ax_i.qmag < QuoW'(ax_i.bump));
  assign slow_diff = ax_i.bump - ax_i.qmag[StepW-1:0];
  assign stretch   = (DelayW+StepW)'(ax_i.base_delay) * (DelayW+StepW)'(slow_diff);
  assign dly_raw   = slow ? stretch[DelayW-1:0] : ax_i.base_delay;

  always_comb begin
    if (zero) begin
      dmag = '0;
    end else if (slow) begin
      dmag = (QuoW+1)'(1);
    end else begin
      dmag = {1'b0, ax_i.qmag} + (QuoW+1)'(1) - (QuoW+1)'(ax_i.bump);
    end
  end

  assign lo_s = $signed({{(QuoW+3-AngleW){1'b0}}, ax_i.lo});
  assign hi_s = $signed({{(QuoW+3-AngleW){1'b0}}, ax_i.hi});

  always_comb begin
    if (ax_i.neg) begin
      sum = $signed({{(QuoW+3-AngleW){1'b0}}, ax_i.angle}) - $signed({2'b00, dmag});
    end else begin
      sum = $signed({{(QuoW+3-AngleW){1'b0}}, ax_i.angle}) + $signed({2'b00, dmag});
    end
    c1 = (sum > hi_s) ? hi_s : sum;
    c2 = (c1 < lo_s) ? lo_s : c1;
  end

  assign ax_o.angle = c2[AngleW-1:0];
  assign ax_o.delay = (dly_raw == '0) ? DelayW'(1) : dly_raw;

endmodule

// ===== tb/testbench.sv =====
// testbench: drives frames and register writes into the pan/tilt servo rate stepper and
// checks each result item against the directed table or its own model of the angle and update delay state
// depends on pts_pkg, the channel interfaces of pts_if and pan_tilt_servo_rate_stepper_top
module testbench;
  import pts_pkg::*;

  localparam int DirRows      = 20;
  localparam int FixPhases    = 5;
  localparam int RndPhases    = 8;
  localparam int PhaseItems   = 100;
  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 150;
  localparam int MaxPrints    = 30;

  typedef struct packed {
    logic                    known;
    logic signed [AxisW-1:0] pan_raw;
    logic signed [AxisW-1:0] tilt_raw;
    logic [FrameW-1:0]       frame;
    logic [AngleW-1:0]       pan_exp;
    logic [AngleW-1:0]       tilt_exp;
  } frame_row_t;

  typedef struct packed {
    logic [AngleW-1:0] pan;
    logic [AngleW-1:0] tilt;
  } angles_t;

  // reset settings first, pan rows then tilt rows follow the same order
  localparam frame_row_t DirTable [DirRows] = '{
    '{1'b1, 11'sd0, 11'sd0, 32'd1, 8'd90, 8'd90},
    '{1'b1, 11'sd0, 11'sd0, 32'd0, 8'd90, 8'd90},
    '{1'b1, -11'sd512, 11'sd512, 32'd2, 8'd95, 8'd90},
    '{1'b1, 11'h400, 11'h400, 32'd4, 8'd108, 8'd103},
    '{1'b1, 11'sd1023, 11'sd1023, 32'd6, 8'd96, 8'd91},
    '{1'b1, -11'sd128, -11'sd64, 32'd8, 8'd97, 8'd92},
    '{1'b1, -11'sd512, 11'sd0, 32'd10, 8'd97, 8'd92},
    '{1'b1, 11'sd100, 11'sd0, 32'd12, 8'd96, 8'd92},
    '{1'b1, 11'h400, 11'h400, 32'd13, 8'd96, 8'd92},
    '{1'b0, 11'h2AA, 11'h555, 32'hAAAA_AAAA, 8'd0, 8'd0},
    '{1'b0, 11'h555, 11'h2AA, 32'h5555_5555, 8'd0, 8'd0},
    '{1'b0, -11'sd1, 11'sd1, 32'hFFFF_FFFF, 8'd0, 8'd0},
    '{1'b0, 11'sd1, -11'sd1, 32'hFFFF_FFFE, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd24, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd30, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd36, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd42, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd48, 8'd0, 8'd0},
    '{1'b0, 11'h400, 11'sd1023, 32'd54, 8'd0, 8'd0},
    '{1'b0, 11'sd0, 11'h400, 32'd60, 8'd0, 8'd0}
  };

  // lowest, highest, zero scale with zero bump and crossed limits, wrapping delay, all ones
  localparam logic [CfgDatW-1:0] FixRegs [FixPhases][8] = '{
    '{10'd1, 10'd0, 10'd1, 10'd1, 10'd0, 10'd180, 10'd0, 10'd180},
    '{10'd512, 10'd64, 10'd64, 10'd255, 10'd0, 10'd180, 10'd0, 10'd180},
    '{10'd0, 10'd40, 10'd0, 10'd0, 10'd150, 10'd20, 10'd120, 10'd60},
    '{10'd300, 10'd16, 10'd6, 10'd128, 10'd10, 10'd170, 10'd30, 10'd160},
    '{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF}
  };

  logic clk_i;
  logic rst_ni;

  pts_in_if  frame_if ();
  pts_out_if angle_if ();
  pts_cfg_if reg_if ();

  pan_tilt_servo_rate_stepper_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (frame_if),
    .out_o  (angle_if),
    .cfg_i  (reg_if)
  );

  cfg_t              model_cfg;
  int                pan_deg;
  int                tilt_deg;
  logic [DelayW-1:0] pan_wait;
  logic [DelayW-1:0] tilt_wait;
  angles_t           pending_angles [$];
  logic [CfgDatW-1:0] next_regs [8];

  bit idle_on = 1'b1;
  int mismatches = 0;
  int frames_sent = 0;
  int angles_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [DelayW-1:0] delay_floor(logic [31:0] d);
    return (d[DelayW-1:0] == '0) ? DelayW'(1) : d[DelayW-1:0];
  endfunction

  function automatic int step_delta(int axis, output logic [DelayW-1:0] wait_nxt);
    int          fs;
    int          stp;
    int          mag;
    int          sgn;
    logic [31:0] stretch;
    fs  = (model_cfg.full_scale == '0) ? 1 : int'(model_cfg.full_scale);
    stp = (int'(model_cfg.max_step) * axis) / fs;
    if (stp == 0) begin
      wait_nxt = delay_floor(32'(model_cfg.base_delay));
      return 0;
    end
    sgn = (stp > 0) ? 1 : -1;
    mag = (stp > 0) ? stp : -stp;
    if (mag < int'(model_cfg.bump)) begin
      stretch  = 32'(model_cfg.base_delay) * (32'(model_cfg.bump) - 32'(mag));
      wait_nxt = delay_floor(stretch);
      return sgn;
    end
    wait_nxt = delay_floor(32'(model_cfg.base_delay));
    return stp - sgn * (int'(model_cfg.bump) - 1);
  endfunction

  function automatic int clamp_deg(int a, logic [AngleW-1:0] lo, logic [AngleW-1:0] hi);
    if (a > int'(hi)) a = int'(hi);
    if (a < int'(lo)) a = int'(lo);
    return a;
  endfunction

  function automatic angles_t advance_angles(frame_row_t row);
    int      pan_axis;
    int      tilt_axis;
    angles_t res;
    pan_axis  = -int'(row.pan_raw);
    tilt_axis = -int'(row.tilt_raw);
    if (row.frame % FrameW'(delay_floor(32'(pan_wait))) == '0) begin
      pan_deg = clamp_deg(pan_deg + step_delta(pan_axis, pan_wait),
                          model_cfg.pan_low, model_cfg.pan_high);
    end
    if (row.frame % FrameW'(delay_floor(32'(tilt_wait))) == '0) begin
      tilt_deg = clamp_deg(tilt_deg + step_delta(tilt_axis, tilt_wait),
                           model_cfg.tilt_low, model_cfg.tilt_high);
    end
    res.pan  = AngleW'(pan_deg);
    res.tilt = AngleW'(tilt_deg);
    return res;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    case (idx)
      RegFullScale: model_cfg.full_scale = data[FsW-1:0];
      RegMaxStep:   model_cfg.max_step   = data[StepW-1:0];
      RegBump:      model_cfg.bump       = data[StepW-1:0];
      RegBaseDelay: model_cfg.base_delay = data[DelayW-1:0];
      RegPanLow:    model_cfg.pan_low    = data[AngleW-1:0];
      RegPanHigh:   model_cfg.pan_high   = data[AngleW-1:0];
      RegTiltLow:   model_cfg.tilt_low   = data[AngleW-1:0];
      RegTiltHigh:  model_cfg.tilt_high  = data[AngleW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [AxisW-1:0] draw_axis();
    int pick;
    int v;
    pick = int'($urandom_range(7, 0));
    if (pick == 0) v = 0;
    else if (pick <= 3) v = int'($urandom_range(400, 0)) - 200;
    else if (pick == 4) v = ($urandom_range(1, 0) == 1) ? -1024 : 1023;
    else v = int'($urandom_range(2047, 0));
    return AxisW'(v);
  endfunction

  function automatic logic [CfgDatW-1:0] draw_reg(int lo, int hi);
    if ($urandom_range(7, 0) == 0) return CfgDatW'($urandom_range(1023, 0));
    return CfgDatW'($urandom_range(hi, lo));
  endfunction

  task automatic draw_span(output logic [CfgDatW-1:0] lo, output logic [CfgDatW-1:0] hi);
    logic [CfgDatW-1:0] a;
    logic [CfgDatW-1:0] b;
    a = draw_reg(0, 180);
    b = draw_reg(0, 180);
    if (a > b && $urandom_range(3, 0) != 0) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrints) $display("mismatch: %s", msg);
  endtask

  task automatic send_frame(input frame_row_t row);
    int gap;
    angles_t model;
    gap = idle_on ? int'($urandom_range(19, 0)) : 0;
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_if.valid          <= 1'b1;
    frame_if.stick_pan_raw  <= row.pan_raw;
    frame_if.stick_tilt_raw <= row.tilt_raw;
    frame_if.frame_index    <= row.frame;
    do @(posedge clk_i); while (!frame_if.ready);
    model = advance_angles(row);
    pending_angles.push_back(row.known ? angles_t'({row.pan_exp, row.tilt_exp}) : model);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic drain_results();
    frame_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    angles_t want;
    int      stall;
    angle_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? int'($urandom_range(19, 0)) : 0;
      if (stall > 0) begin
        angle_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      angle_if.ready <= 1'b1;
      do @(posedge clk_i); while (!angle_if.valid);
      angles_checked++;
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with no item outstanding",
                                  angle_if.pan_angle_out, angle_if.tilt_angle_out));
      end else begin
        want = pending_angles.pop_front();
        if (angle_if.pan_angle_out !== want.pan) begin
          report_mismatch($sformatf("result %0d: pan %0d, expected %0d", angles_checked,
                                    angle_if.pan_angle_out, want.pan));
        end
        if (angle_if.tilt_angle_out !== want.tilt) begin
          report_mismatch($sformatf("result %0d: tilt %0d, expected %0d", angles_checked,
                                    angle_if.tilt_angle_out, want.tilt));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((frame_if.valid && frame_if.ready) || (angle_if.valid && angle_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: nothing moved for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t        row;
    logic [FrameW-1:0] frame_ctr;
    rst_ni                  <= 1'b0;
    frame_if.valid          <= 1'b0;
    frame_if.stick_pan_raw  <= '0;
    frame_if.stick_tilt_raw <= '0;
    frame_if.frame_index    <= '0;
    reg_if.valid            <= 1'b0;
    reg_if.index            <= '0;
    reg_if.data             <= '0;
    model_cfg = '{full_scale: FsW'(512), max_step: StepW'(8), bump: StepW'(4),
                  base_delay: DelayRst, pan_low: '0, pan_high: AngleW'(170),
                  tilt_low: AngleW'(90), tilt_high: AngleW'(150)};
    pan_deg   = int'(AngleRst);
    tilt_deg  = int'(AngleRst);
    pan_wait  = DelayRst;
    tilt_wait = DelayRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) send_frame(DirTable[i]);

    for (int p = 0; p < FixPhases + RndPhases; p++) begin
      drain_results();
      if (p < FixPhases) begin
        next_regs = FixRegs[p];
      end else begin
        next_regs[RegFullScale] = draw_reg(1, 512);
        next_regs[RegMaxStep]   = draw_reg(0, 64);
        next_regs[RegBump]      = draw_reg(1, 64);
        next_regs[RegBaseDelay] = ($urandom_range(3, 0) == 0) ? draw_reg(1, 255)
                                                               : draw_reg(1, 6);
        draw_span(next_regs[RegPanLow], next_regs[RegPanHigh]);
        draw_span(next_regs[RegTiltLow], next_regs[RegTiltHigh]);
      end
      for (int r = int'(RegFullScale); r <= int'(RegTiltHigh); r++) begin
        write_reg(CfgIdxW'(r), next_regs[r]);
      end
      // writes past the last register must leave the settings alone
      if (p == FixPhases - 1 || $urandom_range(1, 0) == 1) begin
        repeat (2) write_reg(RegTiltHigh + CfgIdxW'($urandom_range(8, 1)),
                             CfgDatW'($urandom_range(1023, 0)));
      end
      reg_if.valid <= 1'b0;
      idle_on   = (p % 3 != 2);
      frame_ctr = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(60, 0)
                                              : $urandom;
      repeat (PhaseItems) begin
        row          = '0;
        row.pan_raw  = draw_axis();
        row.tilt_raw = draw_axis();
        if ($urandom_range(7, 0) == 0) begin
          row.frame = $urandom;
        end else begin
          row.frame = frame_ctr;
          frame_ctr = frame_ctr + 1'b1;
        end
        send_frame(row);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("run covered %0d frames over %0d register settings, %0d register writes",
             frames_sent, FixPhases + RndPhases + 1, reg_writes);
    $display("%0d results checked, %0d mismatches", angles_checked, mismatches);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
